@@ rtl/core/bmf_pkg.sv @@
// Package for the binary median filter: payload structs and fixed field widths.
// No dependencies.
package bmf_pkg;

  localparam int CFG_W = 5;

  typedef struct packed {
    logic sample_bit;
    logic end_of_sequence;
  } bmf_in_t;

  typedef struct packed {
    logic filtered_bit;
    logic last_output;
  } bmf_out_t;

endpackage

@@ rtl/core/binary_median_filter.sv @@
// Binary median filter top level: delay line, running ones count, flush control
// and output register. Depends on bmf_pkg.
//
// Majority vote over a window of 2h+1 bits with edge replication; outputs lag
// the input by h items. An ordinary item goes from the input register straight
// to the output register, and a new one may be accepted every cycle while the
// result side takes its items; a stalled result holds the input register, then
// the input. An item carrying end_of_sequence holds the input off while the h
// trailing copies of the last sample go one per cycle, while the result side
// takes them, through the same shift and count update, each giving one result
// once the window is full, the last one marked. No clearing pass after reset.
module binary_median_filter
  import bmf_pkg::*;
#(
  parameter int MAX_HALF = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  bmf_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bmf_out_t        out_data
);

  localparam int WIN_D = 2 * MAX_HALF + 1;
  localparam int IDX_W = $clog2(WIN_D);
  localparam int HW    = IDX_W - 1;
  localparam int CW    = $clog2(WIN_D + 1);

  logic [HW-1:0]    half_r;
  logic [WIN_D-1:0] win_r, win_nxt;
  logic [CW-1:0]    ones_r, ones_nxt;
  logic [CW-1:0]    seen_r, seen_nxt;
  logic             flush_r, flush_nxt;
  logic [HW-1:0]    flush_cnt_r, flush_cnt_nxt;
  logic             fill_bit_r, fill_bit_nxt;
  logic             in_full_r, in_full_nxt;
  bmf_in_t          in_r;
  logic             out_valid_r, out_valid_nxt;
  bmf_out_t         out_r, out_nxt;

  logic             can_go;
  logic             consume;
  logic             push_bit;
  logic [IDX_W-1:0] tap;
  logic [CW-1:0]    len_c;
  logic [CW-1:0]    half_c;
  logic [CW-1:0]    push_ones;
  logic [CW-1:0]    push_seen;

  assign can_go   = !out_valid_r || !out_stall;
  assign consume  = can_go && in_full_r && !flush_r;
  assign in_stall = in_full_r && !consume;

  assign tap    = {half_r, 1'b0};
  assign len_c  = CW'({half_r, 1'b1});
  assign half_c = CW'(half_r);

  assign push_bit  = flush_r ? fill_bit_r : in_r.sample_bit;
  assign push_ones = ones_r - CW'(win_r[tap]) + CW'(push_bit);
  assign push_seen = (seen_r < len_c) ? seen_r + CW'(1) : seen_r;

  always_comb begin
    win_nxt       = win_r;
    ones_nxt      = ones_r;
    seen_nxt      = seen_r;
    flush_nxt     = flush_r;
    flush_cnt_nxt = flush_cnt_r;
    fill_bit_nxt  = fill_bit_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (can_go) begin
      out_valid_nxt     = 1'b0;
      out_nxt.last_output = 1'b0;
      if (flush_r) begin
        win_nxt       = {win_r[WIN_D-2:0], push_bit};
        ones_nxt      = push_ones;
        seen_nxt      = push_seen;
        flush_cnt_nxt = flush_cnt_r - HW'(1);
        out_nxt.filtered_bit = push_ones > half_c;
        out_valid_nxt = push_seen >= len_c;
        if (flush_cnt_r == HW'(1)) begin
          out_nxt.last_output = 1'b1;
          flush_nxt = 1'b0;
          seen_nxt  = '0;
        end
      end else if (in_full_r) begin
        if (seen_r == '0) begin
          win_nxt  = {WIN_D{in_r.sample_bit}};
          ones_nxt = in_r.sample_bit ? len_c : '0;
          seen_nxt = half_c + CW'(1);
          out_nxt.filtered_bit = in_r.sample_bit;
          out_valid_nxt = (half_r == '0);
        end else begin
          win_nxt  = {win_r[WIN_D-2:0], push_bit};
          ones_nxt = push_ones;
          seen_nxt = push_seen;
          out_nxt.filtered_bit = push_ones > half_c;
          out_valid_nxt = push_seen >= len_c;
        end
        if (in_r.end_of_sequence) begin
          if (half_r == '0) begin
            out_nxt.last_output = 1'b1;
            seen_nxt = '0;
          end else begin
            flush_nxt     = 1'b1;
            flush_cnt_nxt = half_r;
            fill_bit_nxt  = in_r.sample_bit;
          end
        end
      end
    end
  end

  assign in_full_nxt = (in_valid && !in_stall) ? 1'b1 : (consume ? 1'b0 : in_full_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HW'(1);
      ones_r      <= '0;
      seen_r      <= '0;
      flush_r     <= 1'b0;
      flush_cnt_r <= '0;
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      if (cfg_we) begin
        half_r  <= (cfg_wdata > CFG_W'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(cfg_wdata);
        ones_r  <= '0;
        seen_r  <= '0;
        flush_r <= 1'b0;
      end else begin
        ones_r  <= ones_nxt;
        seen_r  <= seen_nxt;
        flush_r <= flush_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    fill_bit_r <= fill_bit_nxt;
    out_r      <= out_nxt;
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r && in_full_r |-> in_stall)
    else $error("input consumed during flush");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> flush_cnt_r != '0)
    else $error("flush active with zero count");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= len_c)
    else $error("samples seen beyond window");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_output |-> !flush_r && seen_r == '0)
    else $error("sequence state left after last item");

endmodule

@@ verif/binary_median_filter_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for binary_median_filter: watches config, input and result channels,
// predicts the majority-vote results and compares them in order. Depends on bmf_pkg.
module binary_median_filter_checker
  import bmf_pkg::*;
#(
  parameter int MAX_HALF = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  bmf_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  bmf_out_t         out_data,
  output int               mismatches,
  output int               votes_outstanding
);

  logic [2*MAX_HALF:0] vote_window;
  logic [5:0]          ones_in_window;
  logic [5:0]          window_fill;
  logic [4:0]          half_span;
  bmf_out_t            expected_votes[$];

  initial begin
    mismatches = 0;
    votes_outstanding = 0;
  end

  task automatic clear_window();
    vote_window = '0;
    ones_in_window = '0;
    window_fill = '0;
  endtask

  task automatic apply_half_window(input logic [CFG_W-1:0] value);
    half_span = (int'(value) > MAX_HALF) ? 5'(MAX_HALF) : value;
    clear_window();
  endtask

  task automatic shift_sample(input logic b, output bit window_ready);
    int len;
    len = 2 * half_span + 1;
    ones_in_window = ones_in_window - 6'(vote_window[len-1]);
    vote_window = {vote_window[2*MAX_HALF-1:0], b};
    ones_in_window = ones_in_window + 6'(b);
    if (int'(window_fill) < len) window_fill = window_fill + 6'd1;
    window_ready = (int'(window_fill) >= len);
  endtask

  // Results of one item are held back by one so the final one can be marked.
  task automatic predict_votes(input bmf_in_t item);
    int       len;
    bit       ready;
    bit       have_held;
    bmf_out_t held;
    len = 2 * half_span + 1;
    have_held = 1'b0;
    held = '0;
    if (window_fill == 0) begin
      vote_window = {(2*MAX_HALF+1){item.sample_bit}};
      ones_in_window = item.sample_bit ? 6'(len) : 6'd0;
      window_fill = 6'(half_span + 1);
      ready = (int'(window_fill) >= len);
    end else begin
      shift_sample(item.sample_bit, ready);
    end
    if (ready) begin
      held = '{filtered_bit: (ones_in_window > 6'(half_span)), last_output: 1'b0};
      have_held = 1'b1;
    end
    if (item.end_of_sequence) begin
      repeat (half_span) begin
        shift_sample(item.sample_bit, ready);
        if (ready) begin
          if (have_held) expected_votes.push_back(held);
          held = '{filtered_bit: (ones_in_window > 6'(half_span)), last_output: 1'b0};
          have_held = 1'b1;
        end
      end
      held.last_output = 1'b1;
      clear_window();
    end
    if (have_held) expected_votes.push_back(held);
  endtask

  task automatic check_vote(input bmf_out_t got);
    bmf_out_t want;
    if (expected_votes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected item filtered=%0b last=%0b", $time,
                 got.filtered_bit, got.last_output);
    end else begin
      want = expected_votes.pop_front();
      if (got.filtered_bit !== want.filtered_bit || got.last_output !== want.last_output) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected filtered=%0b last=%0b, got filtered=%0b last=%0b", $time,
                   want.filtered_bit, want.last_output, got.filtered_bit, got.last_output);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_span = 5'd1;
      clear_window();
      expected_votes.delete();
    end else begin
      if (out_valid && !out_stall) check_vote(out_data);
      if (cfg_we) apply_half_window(cfg_wdata);
      if (in_valid && !in_stall) predict_votes(in_data);
    end
    votes_outstanding = expected_votes.size();
  end

endmodule

@@ verif/binary_median_filter_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for binary_median_filter: clock, reset, bursty bit-sequence stimulus,
// receiver stall pattern, watchdog and verdict. Depends on bmf_pkg and the checker.
module binary_median_filter_tb;
  import bmf_pkg::*;

  localparam int MAX_HALF   = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  bmf_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  bmf_out_t         out_data;

  int mismatches;
  int votes_outstanding;
  int items_sent;
  int burst_left;
  int idle_cycles = 0;
  bit long_hold_pending;

  binary_median_filter #(.MAX_HALF(MAX_HALF)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  binary_median_filter_checker #(.MAX_HALF(MAX_HALF)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .mismatches       (mismatches),
    .votes_outstanding(votes_outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    int mode_left;
    int stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{sample_bit: b, end_of_sequence: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (votes_outstanding != 0) @(negedge clk);
  endtask

  task automatic set_half_window(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (MAX_HALF + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends bits[n-1] first.
  task automatic send_bits(input logic [15:0] bits, input int n, input bit close);
    for (int i = n - 1; i >= 0; i--) send_item(bits[i], close && i == 0);
  endtask

  task automatic send_sequence(input int n, input bit close);
    int   flip_pct;
    logic b;
    flip_pct = $urandom_range(3, 60);
    b = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < flip_pct) b = ~b;
      send_item(b, close && i == n - 1);
    end
  endtask

  initial begin : stimulus
    int phase;
    int seqs;
    int len;
    int pick;
    logic [CFG_W-1:0] half_value;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    items_sent = 0;
    burst_left = 0;
    long_hold_pending = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value h = 1: single-sample sequences, a short one, then an abandoned one
    send_bits(16'b1, 1, 1'b1);
    send_bits(16'b0, 1, 1'b1);
    send_bits(16'b10110, 5, 1'b1);
    send_bits(16'b110, 3, 1'b0);
    set_half_window(5'd0);
    send_bits(16'b101, 3, 1'b1);
    send_bits(16'b1, 1, 1'b1);
    set_half_window(5'd31);  // saturates to the largest window
    send_bits(16'b0110, 4, 1'b1);
    send_bits(16'b1, 1, 1'b1);
    set_half_window(5'(MAX_HALF));
    send_bits(16'b10, 2, 1'b1);

    phase = 0;
    while (items_sent < 450) begin
      case (phase)
        0: half_value = 5'(MAX_HALF);
        1: half_value = 5'd0;
        2: half_value = 5'd31;
        default: half_value = 5'($urandom_range(0, 31));
      endcase
      set_half_window(half_value);
      if (phase == 1) long_hold_pending = 1'b1;
      seqs = $urandom_range(3, 8);
      for (int s = 0; s < seqs; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) len = 1;
        else if (pick < 85) len = $urandom_range(2, 24);
        else len = $urandom_range(25, 60);
        send_sequence(len, !(s == seqs - 1 && $urandom_range(0, 3) == 0));
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (MAX_HALF + 4) @(negedge clk);
    if (mismatches == 0 && votes_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bmf_pkg.sv
rtl/core/binary_median_filter.sv
verif/binary_median_filter_checker.sv
verif/binary_median_filter_tb.sv
